>>> rtl/core/psd_pkg.sv
// Package for the point-to-segment distance block.
// Holds bus-packing helpers; depends on nothing.
package psd_pkg;

    localparam int BYTE_BITS = 8;

    // Round a field width up to whole bytes for stream packing.
    function automatic int bytes_up(input int bits);
        return ((bits + BYTE_BITS - 1) / BYTE_BITS) * BYTE_BITS;
    endfunction

endpackage

>>> rtl/core/point_segment_distance.sv
// Point-to-segment distance: fully pipelined, one item per cycle sustained; an output
// stall holds every stage.
// Depth is set by the restoring divider for t (one bit a stage) and by the
// square root (one root bit a stage).
// Asynchronous active-low reset clears all valid bits; data registers are not reset.
// Depends on psd_pkg.
module point_segment_distance #(
    parameter int COORD_WIDTH = 24,
    parameter int T_FRAC_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // seg_start_x, seg_start_y, seg_end_x, seg_end_y, query_x, query_y (low to high)
    input  logic [psd_pkg::bytes_up(6*COORD_WIDTH)-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // seg_distance
    output logic [psd_pkg::bytes_up(COORD_WIDTH+1)-1:0] m_axis_tdata
);
    import psd_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int TF   = T_FRAC_BITS;
    localparam int DW   = CW + 1;          // coordinate differences
    localparam int PW   = 2 * DW;          // products
    localparam int SW   = PW + 2;          // dot, squared length, remainder
    localparam int TW   = TF + 1;          // t, with 1.0 exact
    localparam int MW   = TW + DW;         // t * |d|
    localparam int OMW  = MW - TF;         // projection offset magnitude
    localparam int RXW  = CW + 3;          // residual, signed
    localparam int RMW  = RXW - 1;         // residual magnitude
    localparam int RTW  = RMW + 1;         // root width
    localparam int RW   = 2 * RTW;         // radicand
    localparam int OW   = CW + 1;
    localparam int OPAD = bytes_up(OW);
    localparam int NST  = 4 + TF + 4 + RTW + 1;

    logic en;
    logic [NST-1:0] v_reg;

    assign en            = !v_reg[NST-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = v_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NST-2:0], s_axis_tvalid && s_axis_tready};
        end
    end

    // ---- stage a: differences relative to the start point
    logic signed [CW-1:0] sx, sy, ex, ey, px, py;
    logic signed [DW-1:0] qx_a_reg, qy_a_reg, dx_a_reg, dy_a_reg;

    assign sx = s_axis_tdata[CW-1:0];
    assign sy = s_axis_tdata[2*CW-1:CW];
    assign ex = s_axis_tdata[3*CW-1:2*CW];
    assign ey = s_axis_tdata[4*CW-1:3*CW];
    assign px = s_axis_tdata[5*CW-1:4*CW];
    assign py = s_axis_tdata[6*CW-1:5*CW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qx_a_reg <= DW'(px) - DW'(sx);
            qy_a_reg <= DW'(py) - DW'(sy);
            dx_a_reg <= DW'(ex) - DW'(sx);
            dy_a_reg <= DW'(ey) - DW'(sy);
        end
    end

    // ---- stage b: magnitude products
    logic [DW-1:0] mqx, mqy, mdx, mdy;
    logic [PW-1:0] pxx_b_reg, pyy_b_reg, pqx_b_reg, pqy_b_reg;
    logic          negx_b_reg, negy_b_reg;
    logic signed [DW-1:0] qx_b_reg, qy_b_reg, dx_b_reg, dy_b_reg;

    assign mqx = qx_a_reg[DW-1] ? DW'(-qx_a_reg) : DW'(qx_a_reg);
    assign mqy = qy_a_reg[DW-1] ? DW'(-qy_a_reg) : DW'(qy_a_reg);
    assign mdx = dx_a_reg[DW-1] ? DW'(-dx_a_reg) : DW'(dx_a_reg);
    assign mdy = dy_a_reg[DW-1] ? DW'(-dy_a_reg) : DW'(dy_a_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxx_b_reg  <= mdx * mdx;
            pyy_b_reg  <= mdy * mdy;
            pqx_b_reg  <= mqx * mdx;
            pqy_b_reg  <= mqy * mdy;
            negx_b_reg <= qx_a_reg[DW-1] ^ dx_a_reg[DW-1];
            negy_b_reg <= qy_a_reg[DW-1] ^ dy_a_reg[DW-1];
            qx_b_reg   <= qx_a_reg;
            qy_b_reg   <= qy_a_reg;
            dx_b_reg   <= dx_a_reg;
            dy_b_reg   <= dy_a_reg;
        end
    end

    // ---- stage c: squared length and signed dot product
    logic signed [SW-1:0] tx, ty;
    logic [SW-1:0]        l2_c_reg;
    logic signed [SW-1:0] dot_c_reg;
    logic signed [DW-1:0] qx_c_reg, qy_c_reg, dx_c_reg, dy_c_reg;

    assign tx = negx_b_reg ? -$signed(SW'(pqx_b_reg)) : $signed(SW'(pqx_b_reg));
    assign ty = negy_b_reg ? -$signed(SW'(pqy_b_reg)) : $signed(SW'(pqy_b_reg));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l2_c_reg  <= SW'(pxx_b_reg) + SW'(pyy_b_reg);
            dot_c_reg <= tx + ty;
            qx_c_reg  <= qx_b_reg;
            qy_c_reg  <= qy_b_reg;
            dx_c_reg  <= dx_b_reg;
            dy_c_reg  <= dy_b_reg;
        end
    end

    // ---- stage d and divider: t = floor(dot * 2^TF / l2), one bit a stage
    logic [SW-1:0]        rem_reg  [TF+1];
    logic [SW-1:0]        l2_reg   [TF+1];
    logic [TF-1:0]        q_reg    [TF+1];
    logic                 tzero_reg[TF+1];
    logic                 tone_reg [TF+1];
    logic signed [DW-1:0] gqx_reg  [TF+1];
    logic signed [DW-1:0] gqy_reg  [TF+1];
    logic signed [DW-1:0] gdx_reg  [TF+1];
    logic signed [DW-1:0] gdy_reg  [TF+1];
    logic                 dz;

    assign dz = (l2_c_reg == '0) || (dot_c_reg <= 0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]   <= dot_c_reg;
            l2_reg[0]    <= l2_c_reg;
            q_reg[0]     <= '0;
            tzero_reg[0] <= dz;
            tone_reg[0]  <= !dz && ($unsigned(dot_c_reg) >= l2_c_reg);
            gqx_reg[0]   <= qx_c_reg;
            gqy_reg[0]   <= qy_c_reg;
            gdx_reg[0]   <= dx_c_reg;
            gdy_reg[0]   <= dy_c_reg;
        end
    end

    for (genvar k = 0; k < TF; k++)
    begin : g_div
        logic [SW-1:0] rs;
        logic          ge;
        assign rs = {rem_reg[k][SW-2:0], 1'b0};
        assign ge = rs >= l2_reg[k];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]   <= ge ? rs - l2_reg[k] : rs;
                q_reg[k+1]     <= {q_reg[k][TF-2:0], ge};
                l2_reg[k+1]    <= l2_reg[k];
                tzero_reg[k+1] <= tzero_reg[k];
                tone_reg[k+1]  <= tone_reg[k];
                gqx_reg[k+1]   <= gqx_reg[k];
                gqy_reg[k+1]   <= gqy_reg[k];
                gdx_reg[k+1]   <= gdx_reg[k];
                gdy_reg[k+1]   <= gdy_reg[k];
            end
        end
    end

    // ---- stage e: select t, scale the direction
    logic [TW-1:0]        t_sel;
    logic [DW-1:0]        adx, ady;
    logic [MW-1:0]        mx_e_reg, my_e_reg;
    logic                 ndx_e_reg, ndy_e_reg;
    logic signed [DW-1:0] qx_e_reg, qy_e_reg;

    assign t_sel = tone_reg[TF]  ? TW'(1) << TF :
                   tzero_reg[TF] ? '0 : TW'(q_reg[TF]);
    assign adx = gdx_reg[TF][DW-1] ? DW'(-gdx_reg[TF]) : DW'(gdx_reg[TF]);
    assign ady = gdy_reg[TF][DW-1] ? DW'(-gdy_reg[TF]) : DW'(gdy_reg[TF]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_e_reg  <= MW'(t_sel) * MW'(adx);
            my_e_reg  <= MW'(t_sel) * MW'(ady);
            ndx_e_reg <= gdx_reg[TF][DW-1];
            ndy_e_reg <= gdy_reg[TF][DW-1];
            qx_e_reg  <= gqx_reg[TF];
            qy_e_reg  <= gqy_reg[TF];
        end
    end

    // ---- stage f: floor the offset to the grid, form the residual
    localparam logic [MW-1:0] RND = (MW'(1) << TF) - MW'(1);
    logic [MW-1:0]         mxr, myr;
    logic [OMW-1:0]        oxm, oym;
    logic signed [RXW-1:0] rx, ry;
    logic [RMW-1:0]        arx_f_reg, ary_f_reg;

    assign mxr = ndx_e_reg ? mx_e_reg + RND : mx_e_reg;
    assign myr = ndy_e_reg ? my_e_reg + RND : my_e_reg;
    assign oxm = mxr[MW-1:TF];
    assign oym = myr[MW-1:TF];
    assign rx  = ndx_e_reg ? RXW'(qx_e_reg) + $signed(RXW'(oxm))
                           : RXW'(qx_e_reg) - $signed(RXW'(oxm));
    assign ry  = ndy_e_reg ? RXW'(qy_e_reg) + $signed(RXW'(oym))
                           : RXW'(qy_e_reg) - $signed(RXW'(oym));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            arx_f_reg <= rx[RXW-1] ? RMW'(-rx) : RMW'(rx);
            ary_f_reg <= ry[RXW-1] ? RMW'(-ry) : RMW'(ry);
        end
    end

    // ---- stages g and h: squares, then their sum
    logic [2*RMW-1:0] sqx_g_reg, sqy_g_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_g_reg <= arx_f_reg * arx_f_reg;
            sqy_g_reg <= ary_f_reg * ary_f_reg;
        end
    end

    // ---- square root, one root bit a stage
    logic [RW-1:0]    rad_reg [RTW+1];
    logic [RTW+1:0]   srem_reg[RTW+1];
    logic [RTW-1:0]   root_reg[RTW+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg[0]  <= RW'(sqx_g_reg) + RW'(sqy_g_reg);
            srem_reg[0] <= '0;
            root_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < RTW; k++)
    begin : g_sqrt
        logic [RTW+1:0] r2, trial;
        logic           ok;
        assign r2    = {srem_reg[k][RTW-1:0], rad_reg[k][RW-1:RW-2]};
        assign trial = {root_reg[k], 2'b01};
        assign ok    = r2 >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                srem_reg[k+1] <= ok ? r2 - trial : r2;
                root_reg[k+1] <= {root_reg[k][RTW-2:0], ok};
                rad_reg[k+1]  <= {rad_reg[k][RW-3:0], 2'b00};
            end
        end
    end

    // ---- output register, saturate if the root is too wide
    logic [OW-1:0] dist_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg <= (root_reg[RTW][RTW-1:OW] != '0) ? '1 : root_reg[RTW][OW-1:0];
        end
    end

    assign m_axis_tdata = OPAD'(dist_reg);

    // ---- checks
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while output stalled");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> v_reg[0])
        else $error("accepted item lost at entry");

    a_t_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[3] |-> !(tzero_reg[0] && tone_reg[0]))
        else $error("t both zero and one");

endmodule
